/* design/homogeneous_point_transform_core_defines.svh */
// ----------------------------------------------------------------------------
// homogeneous point transform assertion macros
// shared assertion forms for the transform core
// ----------------------------------------------------------------------------
`ifndef HOMOGENEOUS_POINT_TRANSFORM_CORE_DEFINES_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_CORE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define HPT_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define HPT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* design/hpt_pkg.sv */
// ----------------------------------------------------------------------------
// hpt_pkg
// shared types, widths and constants of the homogeneous point transform
// ----------------------------------------------------------------------------
package hpt_pkg;

	localparam int FracBits = 16;
	localparam int DataW = 32;
	localparam int DivW = DataW + FracBits;
	localparam int DivSteps = DivW;
	localparam int LaneSumW = 2 * DataW + 4;

	typedef enum logic [1:0] {
		MODE_LOAD = 2'd0,
		MODE_POINT = 2'd1,
		MODE_DIR = 2'd2,
		MODE_DIR_T = 2'd3
	} mode_t;

	typedef logic signed [DataW-1:0] word_t;

	typedef struct packed {
		logic point;
		logic [2:0] lane_ovf;
		logic w_zero;
		logic w_one;
	} ctl_t;

	localparam logic signed [DataW-1:0] SatMax = {1'b0, {(DataW-1){1'b1}}};
	localparam logic signed [DataW-1:0] SatMin = {1'b1, {(DataW-1){1'b0}}};
	localparam logic signed [DataW-1:0] OneVal = DataW'(1) << FracBits;

	// saturate a wide signed value to one word
	function automatic logic [DataW:0] sat_word(input logic signed [LaneSumW-1:0] v);
		logic [DataW:0] r;
		r = {1'b0, v[DataW-1:0]};
		if (v > LaneSumW'(SatMax)) r = {1'b1, SatMax};
		else if (v < LaneSumW'(SatMin)) r = {1'b1, SatMin};
		return r;
	endfunction

endpackage

/* design/hpt_lane.sv */
// ----------------------------------------------------------------------------
// hpt_lane
// one dot-product lane: three products, floored sum, saturation
// ----------------------------------------------------------------------------
module hpt_lane (
	input logic clk,
	input logic en_s1,
	input logic en_s2,
	input hpt_pkg::word_t a0,
	input hpt_pkg::word_t a1,
	input hpt_pkg::word_t a2,
	input hpt_pkg::word_t bias,
	input hpt_pkg::word_t v0,
	input hpt_pkg::word_t v1,
	input hpt_pkg::word_t v2,
	output hpt_pkg::word_t res_s2,
	output logic ovf_s2
);

	logic signed [2*hpt_pkg::DataW-1:0] p0_s1, p1_s1, p2_s1;
	hpt_pkg::word_t bias_s1;
	logic signed [hpt_pkg::LaneSumW-1:0] sum;
	logic [hpt_pkg::DataW:0] sat;

	// products registered
	always_ff @(posedge clk) begin
		if (en_s1) begin
			p0_s1 <= a0 * v0;
			p1_s1 <= a1 * v1;
			p2_s1 <= a2 * v2;
			bias_s1 <= bias;
		end
	end

	// exact sum floored once equals arithmetic shift of the full sum
	always_comb begin
		sum = (hpt_pkg::LaneSumW'(p0_s1) + hpt_pkg::LaneSumW'(p1_s1)
			+ hpt_pkg::LaneSumW'(p2_s1)) >>> hpt_pkg::FracBits;
		sum = sum + hpt_pkg::LaneSumW'(bias_s1);
		sat = hpt_pkg::sat_word(sum);
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			res_s2 <= sat[hpt_pkg::DataW-1:0];
			ovf_s2 <= sat[hpt_pkg::DataW];
		end
	end

endmodule

/* design/hpt_div.sv */
// ----------------------------------------------------------------------------
// hpt_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module hpt_div (
	input logic clk,
	input logic [hpt_pkg::DivSteps:0] en,
	input hpt_pkg::word_t num,
	input hpt_pkg::word_t den,
	output logic [hpt_pkg::DivW-1:0] quo,
	output logic neg
);

	localparam int W = hpt_pkg::DivW;

	logic [W-1:0] q_s [hpt_pkg::DivSteps+1];
	logic [W:0] r_s [hpt_pkg::DivSteps+1];
	logic [hpt_pkg::DataW-1:0] d_s [hpt_pkg::DivSteps+1];
	logic neg_s [hpt_pkg::DivSteps+1];

	// magnitudes of the scaled numerator and denominator
	always_ff @(posedge clk) begin
		if (en[0]) begin
			q_s[0] <= num[hpt_pkg::DataW-1] ?
				{hpt_pkg::DataW'(-num), {hpt_pkg::FracBits{1'b0}}} :
				{num, {hpt_pkg::FracBits{1'b0}}};
			d_s[0] <= den[hpt_pkg::DataW-1] ? hpt_pkg::DataW'(-den) : den;
			r_s[0] <= '0;
			neg_s[0] <= num[hpt_pkg::DataW-1] ^ den[hpt_pkg::DataW-1];
		end
	end

	// one bit per stage
	for (genvar k = 0; k < hpt_pkg::DivSteps; k++) begin : g_stage
		logic [W:0] rt;
		logic [W:0] diff;
		always_comb begin
			rt = {r_s[k][W-1:0], q_s[k][W-1]};
			diff = rt - (W+1)'(d_s[k]);
		end
		always_ff @(posedge clk) begin
			if (en[k+1]) begin
				r_s[k+1] <= diff[W] ? rt : diff;
				q_s[k+1] <= {q_s[k][W-2:0], ~diff[W]};
				d_s[k+1] <= d_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	assign quo = q_s[hpt_pkg::DivSteps];
	assign neg = neg_s[hpt_pkg::DivSteps];

endmodule

/* design/hpt_merge.sv */
// ----------------------------------------------------------------------------
// hpt_merge
// combines lane results, divided values and w tests into one result beat
// ----------------------------------------------------------------------------
module hpt_merge (
	input hpt_pkg::ctl_t ctl,
	input hpt_pkg::word_t raw [3],
	input logic [hpt_pkg::DivW-1:0] quo [3],
	input logic [2:0] neg,
	output hpt_pkg::word_t res [3],
	output logic fault,
	output logic ovf
);

	logic [2:0] dovf;

	// select pass, divide or zero-w saturation per component
	always_comb begin
		dovf = '0;
		for (int i = 0; i < 3; i++) begin
			res[i] = raw[i];
			if (ctl.point && ctl.w_zero) begin
				if (raw[i] == '0) res[i] = '0;
				else res[i] = raw[i][hpt_pkg::DataW-1] ? hpt_pkg::SatMin : hpt_pkg::SatMax;
			end else if (ctl.point && !ctl.w_one) begin
				if (neg[i]) begin
					if (quo[i] > hpt_pkg::DivW'({1'b1, {(hpt_pkg::DataW-1){1'b0}}})) begin
						res[i] = hpt_pkg::SatMin;
						dovf[i] = 1'b1;
					end else begin
						res[i] = hpt_pkg::DataW'(-quo[i]);
					end
				end else if (quo[i] > hpt_pkg::DivW'(hpt_pkg::SatMax)) begin
					res[i] = hpt_pkg::SatMax;
					dovf[i] = 1'b1;
				end else begin
					res[i] = quo[i][hpt_pkg::DataW-1:0];
				end
			end
		end
		fault = ctl.point && ctl.w_zero;
		ovf = (|ctl.lane_ovf) || (|dovf);
	end

endmodule

/* design/homogeneous_point_transform_core.sv */
// ----------------------------------------------------------------------------
// homogeneous_point_transform_core
// 4x4 Q16.16 matrix transform of 3-vectors in point and direction modes
// ----------------------------------------------------------------------------
// Takes one beat per cycle while s_tready is high. Load beats write one matrix
// entry and give no result; every other beat gives one result after passing
// through the four dot-product lanes (multiply, then sum) and the
// one-bit-per-stage divider pipeline that all beats pass through. The pipeline
// advances whenever its output register is empty or being taken, so tready is
// low only while a result waits.
module homogeneous_point_transform_core (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// mode[1:0], entry_col[3:2], entry_row[5:4], entry_value[37:6],
	// in_x[69:38], in_y[101:70], in_z[133:102]
	input logic [135:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// out_x[31:0], out_y[63:32], out_z[95:64], divide_fault[96], overflow[97]
	output logic [103:0] m_tdata
);

	`include "homogeneous_point_transform_core_defines.svh"

	localparam int Depth = hpt_pkg::DivSteps + 3;

	hpt_pkg::word_t mat_q [16];
	logic adv;
	logic take;
	logic [1:0] mode;
	hpt_pkg::word_t vin [3];
	hpt_pkg::word_t a [4][3];
	hpt_pkg::word_t bias [4];
	logic [Depth-1:0] vld_q;
	logic [Depth-1:0] pt_q;
	hpt_pkg::word_t res_s2 [4];
	logic [3:0] ovf_s2;
	hpt_pkg::word_t raw_q [hpt_pkg::DivSteps+1][3];
	hpt_pkg::ctl_t ctl_q [hpt_pkg::DivSteps+1];
	logic [hpt_pkg::DivW-1:0] quo [3];
	logic [2:0] neg;
	hpt_pkg::word_t mres [3];
	logic mfault, movf;
	logic [103:0] out_q;
	logic out_v_q;

	assign adv = !out_v_q || m_tready;
	assign s_tready = adv;
	assign take = s_tvalid && s_tready;
	assign mode = s_tdata[1:0];
	assign vin[0] = s_tdata[69:38];
	assign vin[1] = s_tdata[101:70];
	assign vin[2] = s_tdata[133:102];

	// matrix store, column*4+row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				mat_q[i] <= (i[1:0] == i[3:2]) ? hpt_pkg::OneVal : '0;
		end else if (take && mode == hpt_pkg::MODE_LOAD) begin
			mat_q[{s_tdata[3:2], s_tdata[5:4]}] <= s_tdata[37:6];
		end
	end

	// coefficient selection per lane, lane 3 gives w
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			bias[i] = (mode == hpt_pkg::MODE_POINT) ? mat_q[{2'd3, 2'(i)}] : '0;
			for (int j = 0; j < 3; j++)
				a[i][j] = (mode == hpt_pkg::MODE_DIR_T) ? mat_q[{2'(i), 2'(j)}]
					: mat_q[{2'(j), 2'(i)}];
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_lane
		hpt_lane u_lane (
			.clk(clk), .en_s1(adv), .en_s2(adv),
			.a0(a[i][0]), .a1(a[i][1]), .a2(a[i][2]), .bias(bias[i]),
			.v0(vin[0]), .v1(vin[1]), .v2(vin[2]),
			.res_s2(res_s2[i]), .ovf_s2(ovf_s2[i])
		);
		if (i < 3) begin : g_div
			hpt_div u_div (
				.clk(clk), .en({(hpt_pkg::DivSteps+1){adv}}),
				.num(res_s2[i]), .den(res_s2[3]),
				.quo(quo[i]), .neg(neg[i])
			);
		end
	end

	// valid and mode tracking alongside the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			pt_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[Depth-2:0], take && mode != hpt_pkg::MODE_LOAD};
			pt_q <= {pt_q[Depth-2:0], mode == hpt_pkg::MODE_POINT};
		end
	end

	// lane results delayed to meet the divider output
	always_ff @(posedge clk) begin
		if (adv) begin
			raw_q[0] <= res_s2[0:2];
			ctl_q[0] <= '{point: pt_q[1],
				lane_ovf: {ovf_s2[2] | ovf_s2[3] & pt_q[1], ovf_s2[1], ovf_s2[0]},
				w_zero: res_s2[3] == '0, w_one: res_s2[3] == hpt_pkg::OneVal};
			for (int k = 1; k < hpt_pkg::DivSteps + 1; k++) begin
				raw_q[k] <= raw_q[k-1];
				ctl_q[k] <= ctl_q[k-1];
			end
		end
	end

	hpt_merge u_merge (
		.ctl(ctl_q[hpt_pkg::DivSteps]), .raw(raw_q[hpt_pkg::DivSteps]), .quo(quo),
		.neg(neg), .res(mres), .fault(mfault), .ovf(movf)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			out_q <= '0;
		end else if (adv) begin
			out_v_q <= vld_q[Depth-1];
			out_q <= {6'd0, movf, mfault, mres[2], mres[1], mres[0]};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

	`HPT_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`HPT_ASSERT_IMPL(a_known, m_tvalid, !$isunknown(m_tdata))
	`HPT_ASSERT_IMPL(a_ready, m_tvalid && !m_tready, !s_tready)

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// stream-level test of the homogeneous point transform core: matrix loads,
// point, direction and transposed-direction beats against an in-bench Q16.16
// predictor, with random gaps on both sides of the stream
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

	typedef struct {
		hpt_pkg::word_t x;
		hpt_pkg::word_t y;
		hpt_pkg::word_t z;
		logic fault;
		logic ovf;
	} result_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [135:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [103:0] m_tdata;

	hpt_pkg::word_t matrix[16];
	result_t pending_results[$];
	logic sat_hit;
	int mismatches;
	int idle_cycles;
	logic send_calm;
	logic take_calm;

	homogeneous_point_transform_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// clock, 10 ns period
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// saturate to one word, noting any clipping
	function automatic longint clamp(input longint v);
		if (v > 64'sd2147483647) begin
			sat_hit = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat_hit = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint entry(input int col, input int row);
		return longint'(matrix[col * 4 + row]);
	endfunction

	// exact three-term dot product plus bias, floored once
	function automatic longint dot_floor(input longint a0, a1, a2, v0, v1, v2, bias);
		longint p[3];
		longint hi;
		longint lo;
		longint mask;
		mask = (64'sd1 <<< hpt_pkg::FracBits) - 1;
		p[0] = a0 * v0;
		p[1] = a1 * v1;
		p[2] = a2 * v2;
		hi = bias;
		lo = 0;
		for (int i = 0; i < 3; i++) begin
			hi += p[i] >>> hpt_pkg::FracBits;
			lo += p[i] & mask;
		end
		return hi + (lo >>> hpt_pkg::FracBits);
	endfunction

	// apply one beat to the matrix copy; returns 1 when a result is due
	function automatic bit transform_vector(input logic [135:0] d, output result_t r);
		hpt_pkg::mode_t mode;
		longint v[3];
		longint res[3];
		longint w;
		longint one;
		mode = hpt_pkg::mode_t'(d[1:0]);
		if (mode == hpt_pkg::MODE_LOAD) begin
			matrix[d[3:2] * 4 + d[5:4]] = d[37:6];
			return 1'b0;
		end
		one = 64'sd1 <<< hpt_pkg::FracBits;
		v[0] = longint'(hpt_pkg::word_t'(d[69:38]));
		v[1] = longint'(hpt_pkg::word_t'(d[101:70]));
		v[2] = longint'(hpt_pkg::word_t'(d[133:102]));
		sat_hit = 1'b0;
		r.fault = 1'b0;
		if (mode == hpt_pkg::MODE_POINT) begin
			w = clamp(dot_floor(entry(0, 3), entry(1, 3), entry(2, 3),
				v[0], v[1], v[2], entry(3, 3)));
			for (int i = 0; i < 3; i++)
				res[i] = clamp(dot_floor(entry(0, i), entry(1, i), entry(2, i),
					v[0], v[1], v[2], entry(3, i)));
			if (w == 0) begin
				r.fault = 1'b1;
				for (int i = 0; i < 3; i++)
					res[i] = res[i] > 0 ? 64'sd2147483647 :
						(res[i] < 0 ? -64'sd2147483648 : 0);
			end else if (w != one) begin
				for (int i = 0; i < 3; i++)
					res[i] = clamp((res[i] * one) / w);
			end
		end else begin
			for (int i = 0; i < 3; i++)
				if (mode == hpt_pkg::MODE_DIR)
					res[i] = clamp(dot_floor(entry(0, i), entry(1, i), entry(2, i),
						v[0], v[1], v[2], 0));
				else
					res[i] = clamp(dot_floor(entry(i, 0), entry(i, 1), entry(i, 2),
						v[0], v[1], v[2], 0));
		end
		r.x = hpt_pkg::word_t'(res[0]);
		r.y = hpt_pkg::word_t'(res[1]);
		r.z = hpt_pkg::word_t'(res[2]);
		r.ovf = sat_hit;
		return 1'b1;
	endfunction

	function automatic logic [135:0] pack_beat(input hpt_pkg::mode_t mode,
			input int col, row, input hpt_pkg::word_t value, x, y, z);
		return {2'b00, z, y, x, value, 2'(row), 2'(col), mode};
	endfunction

	// send one beat after a random gap; tvalid stays high if the next gap is zero
	task automatic send_beat(input logic [135:0] d);
		int gap;
		logic ready;
		result_t r;
		if ($urandom_range(0, 15) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do begin
			@(negedge clk);
			ready = s_tready;
			@(posedge clk);
		end while (!ready);
		if (transform_vector(d, r))
			pending_results.push_back(r);
	endtask

	task automatic load_entry(input int col, row, input hpt_pkg::word_t value);
		send_beat(pack_beat(hpt_pkg::MODE_LOAD, col, row, value, 0, 0, 0));
	endtask

	task automatic send_vector(input hpt_pkg::mode_t mode, input hpt_pkg::word_t x, y, z);
		send_beat(pack_beat(mode, $urandom_range(0, 3), $urandom_range(0, 3),
			$urandom, x, y, z));
	endtask

	// small Q16.16 value, roughly within +/- 4.0
	function automatic hpt_pkg::word_t near_unit();
		return hpt_pkg::word_t'($urandom_range(0, 1 << 19)) - (1 << 18);
	endfunction

	function automatic hpt_pkg::word_t any_word();
		case ($urandom_range(0, 5))
			0: return hpt_pkg::SatMax;
			1: return hpt_pkg::SatMin;
			2, 3: return $urandom;
			default: return near_unit();
		endcase
	endfunction

	// reset identity, extremes of the vector fields
	task automatic test_identity();
		send_vector(hpt_pkg::MODE_POINT, hpt_pkg::SatMax, hpt_pkg::SatMin, 0);
		send_vector(hpt_pkg::MODE_DIR, hpt_pkg::SatMin, hpt_pkg::SatMax, -1);
		send_vector(hpt_pkg::MODE_DIR_T, 1, hpt_pkg::OneVal, hpt_pkg::SatMax);
	endtask

	// asymmetric 3x3 so that both direction modes differ, then overflow
	task automatic test_directions();
		load_entry(1, 0, 2 * hpt_pkg::OneVal);
		load_entry(2, 1, -3 * hpt_pkg::OneVal);
		load_entry(0, 2, hpt_pkg::OneVal / 2);
		send_vector(hpt_pkg::MODE_DIR, hpt_pkg::OneVal, 3 * hpt_pkg::OneVal,
			-hpt_pkg::OneVal);
		send_vector(hpt_pkg::MODE_DIR_T, hpt_pkg::OneVal, 3 * hpt_pkg::OneVal,
			-hpt_pkg::OneVal);
		load_entry(0, 0, hpt_pkg::SatMax);
		send_vector(hpt_pkg::MODE_DIR, hpt_pkg::SatMax, hpt_pkg::SatMax,
			hpt_pkg::SatMax);
		send_vector(hpt_pkg::MODE_DIR_T, hpt_pkg::SatMin, hpt_pkg::SatMin,
			hpt_pkg::SatMin);
	endtask

	// unit w, general w, zero w, negative w
	task automatic test_point_w();
		load_entry(3, 0, hpt_pkg::OneVal);
		load_entry(3, 1, -hpt_pkg::OneVal);
		send_vector(hpt_pkg::MODE_POINT, 5 * hpt_pkg::OneVal, 7, -9);
		load_entry(3, 3, 2 * hpt_pkg::OneVal);
		send_vector(hpt_pkg::MODE_POINT, 5 * hpt_pkg::OneVal, 7, -9);
		load_entry(3, 3, 0);
		send_vector(hpt_pkg::MODE_POINT, 5 * hpt_pkg::OneVal, 0, 0);
		send_vector(hpt_pkg::MODE_POINT, 0, 0, 0);
		load_entry(3, 3, 1);
		send_vector(hpt_pkg::MODE_POINT, hpt_pkg::SatMax, hpt_pkg::SatMax, 0);
		load_entry(3, 3, hpt_pkg::SatMin);
		send_vector(hpt_pkg::MODE_POINT, hpt_pkg::OneVal, -hpt_pkg::OneVal, 3);
	endtask

	// random matrices and vectors, weighted toward small values and special w
	task automatic test_random(input int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 19);
			if (pick < 4) begin
				load_entry($urandom_range(0, 3), $urandom_range(0, 3),
					$urandom_range(0, 3) == 0 ? any_word() : near_unit());
			end else if (pick == 4) begin
				// force the bottom row to unit or zero w
				load_entry(0, 3, 0);
				load_entry(1, 3, 0);
				load_entry(2, 3, 0);
				load_entry(3, 3, $urandom_range(0, 1) ? hpt_pkg::OneVal : 0);
			end else begin
				send_vector(hpt_pkg::mode_t'($urandom_range(1, 3)),
					$urandom_range(0, 3) == 0 ? any_word() : near_unit(),
					$urandom_range(0, 3) == 0 ? any_word() : near_unit(),
					$urandom_range(0, 3) == 0 ? any_word() : near_unit());
			end
		end
	endtask

	// result side: random stalls, compare against the oldest expectation
	initial begin
		int gap;
		logic valid;
		logic [103:0] d;
		result_t e;
		m_tready = 1'b0;
		take_calm = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0)
				take_calm = !take_calm;
			gap = take_calm ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do begin
				@(negedge clk);
				valid = m_tvalid;
				d = m_tdata;
				@(posedge clk);
			end while (!valid);
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h", d);
			end else begin
				e = pending_results.pop_front();
				if (d[31:0] !== e.x || d[63:32] !== e.y || d[95:64] !== e.z ||
						d[96] !== e.fault || d[97] !== e.ovf) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp x=%h y=%h z=%h f=%b o=%b,",
							" got x=%h y=%h z=%h f=%b o=%b"},
							e.x, e.y, e.z, e.fault, e.ovf,
							d[31:0], d[63:32], d[95:64], d[96], d[97]);
				end
			end
		end
	end

	// watchdog on cycles with no beat moving
	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 3000) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		mismatches = 0;
		idle_cycles = 0;
		send_calm = 1'b0;
		for (int i = 0; i < 16; i++)
			matrix[i] = (i % 5 == 0) ? hpt_pkg::OneVal : '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_identity();
		test_directions();
		test_point_w();
		test_random(630);
		s_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (hpt_pkg::DivW + 20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
